>>> hdl/tl_pkg.sv
// Shared types, token codes and character constants of the token lexer.
package tl_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [1:0] R_CHAR  = 2'd0;
  localparam logic [1:0] R_TOKEN = 2'd1;
  localparam logic [1:0] R_ERROR = 2'd2;

  localparam logic [3:0] K_EOF    = 4'd0;
  localparam logic [3:0] K_EQ     = 4'd1;
  localparam logic [3:0] K_GT     = 4'd2;
  localparam logic [3:0] K_GE     = 4'd3;
  localparam logic [3:0] K_LT     = 4'd4;
  localparam logic [3:0] K_LE     = 4'd5;
  localparam logic [3:0] K_PLUS   = 4'd6;
  localparam logic [3:0] K_MINUS  = 4'd7;
  localparam logic [3:0] K_STAR   = 4'd8;
  localparam logic [3:0] K_SLASH  = 4'd9;
  localparam logic [3:0] K_LPAREN = 4'd10;
  localparam logic [3:0] K_RPAREN = 4'd11;
  localparam logic [3:0] K_ACTION = 4'd12;
  localparam logic [3:0] K_NUMBER = 4'd13;
  localparam logic [3:0] K_IDENT  = 4'd14;

  localparam logic [1:0] E_TOKEN   = 2'd0;
  localparam logic [1:0] E_KEYWORD = 2'd1;
  localparam logic [1:0] E_NUMBER  = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_N      = 8'h6E;

  typedef struct packed {
    logic [1:0] rtype;
    logic [3:0] kind;
    logic [7:0] ch;
    logic [1:0] err;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

>>> hdl/tl_front.sv
// Front end of the token lexer: input handshake, lexing state machine and result building.
module tl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           end_of_input,
  input  logic           q_full,
  output tl_pkg::push_t  q_push
);
  import tl_pkg::*;

  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_COMMENT  = 4'd1;
  localparam logic [3:0] M_GT       = 4'd2;
  localparam logic [3:0] M_LT       = 4'd3;
  localparam logic [3:0] M_COLON    = 4'd4;
  localparam logic [3:0] M_KW_A     = 4'd5;
  localparam logic [3:0] M_KW_AC    = 4'd6;
  localparam logic [3:0] M_KW_ACT   = 4'd7;
  localparam logic [3:0] M_KW_ACTI  = 4'd8;
  localparam logic [3:0] M_KW_ACTIO = 4'd9;
  localparam logic [3:0] M_INT      = 4'd10;
  localparam logic [3:0] M_FRAC     = 4'd11;
  localparam logic [3:0] M_IDENT    = 4'd12;
  localparam logic [3:0] M_FAIL     = 4'd13;

  typedef struct packed {
    logic       emit;
    result_t    res;
    logic [3:0] mode;
  } idle_t;

  logic [3:0] mode;
  logic [3:0] mode_next;
  logic       accept;
  logic [1:0] n;
  result_t    r0;
  result_t    r1;
  idle_t      il;
  logic       is_dig;
  logic       is_ids;
  logic [7:0] kw_exp;

  function automatic result_t mk(input logic [1:0] t, input logic [3:0] k,
                                 input logic [7:0] c, input logic [1:0] e);
    result_t r;
    r.rtype = t;
    r.kind  = k;
    r.ch    = c;
    r.err   = e;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic id_start(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           (c == CH_UNDER);
  endfunction

  function automatic idle_t idle_lex(input logic [7:0] c);
    idle_t o;
    o.emit = 1'b0;
    o.res  = mk(R_TOKEN, K_EOF, 8'd0, E_TOKEN);
    o.mode = M_IDLE;
    if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF)) begin
      o.mode = M_IDLE;
    end else if (c == CH_SEMI) begin
      o.mode = M_COMMENT;
    end else if (c == CH_EQ) begin
      o.emit = 1'b1;
      o.res  = mk(R_TOKEN, K_EQ, 8'd0, E_TOKEN);
    end else if (c == CH_PLUS) begin
      o.emit = 1'b1;
      o.res  = mk(R_TOKEN, K_PLUS, 8'd0, E_TOKEN);
    end else if (c == CH_MINUS) begin
      o.emit = 1'b1;
      o.res  = mk(R_TOKEN, K_MINUS, 8'd0, E_TOKEN);
    end else if (c == CH_STAR) begin
      o.emit = 1'b1;
      o.res  = mk(R_TOKEN, K_STAR, 8'd0, E_TOKEN);
    end else if (c == CH_SLASH) begin
      o.emit = 1'b1;
      o.res  = mk(R_TOKEN, K_SLASH, 8'd0, E_TOKEN);
    end else if (c == CH_LPAREN) begin
      o.emit = 1'b1;
      o.res  = mk(R_TOKEN, K_LPAREN, 8'd0, E_TOKEN);
    end else if (c == CH_RPAREN) begin
      o.emit = 1'b1;
      o.res  = mk(R_TOKEN, K_RPAREN, 8'd0, E_TOKEN);
    end else if (c == CH_GT) begin
      o.mode = M_GT;
    end else if (c == CH_LT) begin
      o.mode = M_LT;
    end else if (c == CH_COLON) begin
      o.mode = M_COLON;
    end else if (c == CH_DOT) begin
      o.emit = 1'b1;
      o.res  = mk(R_CHAR, K_NUMBER, c, E_TOKEN);
      o.mode = M_FRAC;
    end else if (digit(c)) begin
      o.emit = 1'b1;
      o.res  = mk(R_CHAR, K_NUMBER, c, E_TOKEN);
      o.mode = M_INT;
    end else if (id_start(c)) begin
      o.emit = 1'b1;
      o.res  = mk(R_CHAR, K_IDENT, c, E_TOKEN);
      o.mode = M_IDENT;
    end else begin
      o.emit = 1'b1;
      o.res  = mk(R_ERROR, K_EOF, 8'd0, E_TOKEN);
      o.mode = M_FAIL;
    end
    return o;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign il       = idle_lex(in_byte);
  assign is_dig   = digit(in_byte);
  assign is_ids   = id_start(in_byte);

  always_comb begin
    unique case (mode)
      M_COLON:    kw_exp = CH_LA;
      M_KW_A:     kw_exp = CH_C;
      M_KW_AC:    kw_exp = CH_T;
      M_KW_ACT:   kw_exp = CH_I;
      M_KW_ACTI:  kw_exp = CH_O;
      default:    kw_exp = CH_N;
    endcase
  end

  always_comb begin
    n         = 2'd0;
    r0        = mk(R_TOKEN, K_EOF, 8'd0, E_TOKEN);
    r1        = mk(R_TOKEN, K_EOF, 8'd0, E_TOKEN);
    mode_next = mode;
    if (end_of_input) begin
      unique case (mode)
        M_IDLE, M_COMMENT: begin
          n         = 2'd1;
          mode_next = M_IDLE;
        end
        M_GT, M_LT, M_INT, M_FRAC, M_IDENT: begin
          n         = 2'd2;
          mode_next = M_IDLE;
          if (mode == M_GT) begin
            r0 = mk(R_TOKEN, K_GT, 8'd0, E_TOKEN);
          end else if (mode == M_LT) begin
            r0 = mk(R_TOKEN, K_LT, 8'd0, E_TOKEN);
          end else if (mode == M_IDENT) begin
            r0 = mk(R_TOKEN, K_IDENT, 8'd0, E_TOKEN);
          end else begin
            r0 = mk(R_TOKEN, K_NUMBER, 8'd0, E_TOKEN);
          end
        end
        M_COLON, M_KW_A, M_KW_AC, M_KW_ACT, M_KW_ACTI, M_KW_ACTIO: begin
          n         = 2'd1;
          r0        = mk(R_ERROR, K_EOF, 8'd0, E_KEYWORD);
          mode_next = M_FAIL;
        end
        default: begin
          mode_next = M_FAIL;
        end
      endcase
    end else begin
      unique case (mode)
        M_IDLE: begin
          n         = {1'b0, il.emit};
          r0        = il.res;
          mode_next = il.mode;
        end
        M_COMMENT: begin
          if ((in_byte == CH_CR) || (in_byte == CH_LF)) begin
            mode_next = M_IDLE;
          end
        end
        M_GT, M_LT: begin
          if (in_byte == CH_EQ) begin
            n         = 2'd1;
            r0        = mk(R_TOKEN, (mode == M_GT) ? K_GE : K_LE, 8'd0, E_TOKEN);
            mode_next = M_IDLE;
          end else begin
            n         = il.emit ? 2'd2 : 2'd1;
            r0        = mk(R_TOKEN, (mode == M_GT) ? K_GT : K_LT, 8'd0, E_TOKEN);
            r1        = il.res;
            mode_next = il.mode;
          end
        end
        M_COLON, M_KW_A, M_KW_AC, M_KW_ACT, M_KW_ACTI, M_KW_ACTIO: begin
          if (in_byte != kw_exp) begin
            n         = 2'd1;
            r0        = mk(R_ERROR, K_EOF, 8'd0, E_KEYWORD);
            mode_next = M_FAIL;
          end else if (mode == M_KW_ACTIO) begin
            n         = 2'd1;
            r0        = mk(R_TOKEN, K_ACTION, 8'd0, E_TOKEN);
            mode_next = M_IDLE;
          end else begin
            mode_next = mode + 4'd1;
          end
        end
        M_INT, M_FRAC: begin
          if (is_dig) begin
            n  = 2'd1;
            r0 = mk(R_CHAR, K_NUMBER, in_byte, E_TOKEN);
          end else if (in_byte == CH_DOT) begin
            n = 2'd1;
            if (mode == M_FRAC) begin
              r0        = mk(R_ERROR, K_EOF, 8'd0, E_NUMBER);
              mode_next = M_FAIL;
            end else begin
              r0        = mk(R_CHAR, K_NUMBER, in_byte, E_TOKEN);
              mode_next = M_FRAC;
            end
          end else begin
            n         = il.emit ? 2'd2 : 2'd1;
            r0        = mk(R_TOKEN, K_NUMBER, 8'd0, E_TOKEN);
            r1        = il.res;
            mode_next = il.mode;
          end
        end
        M_IDENT: begin
          if (is_dig || is_ids) begin
            n  = 2'd1;
            r0 = mk(R_CHAR, K_IDENT, in_byte, E_TOKEN);
          end else begin
            n         = il.emit ? 2'd2 : 2'd1;
            r0        = mk(R_TOKEN, K_IDENT, 8'd0, E_TOKEN);
            r1        = il.res;
            mode_next = il.mode;
          end
        end
        default: begin
          mode_next = M_FAIL;
        end
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  always_comb begin
    q_push.push      = accept && (n != 2'd0);
    q_push.entry.two = (n == 2'd2);
    q_push.entry.r0  = r0;
    q_push.entry.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

>>> hdl/tl_queue.sv
// Short queue of result groups between the lexer front end and the output stage.
module tl_queue #(
  parameter int DEPTH = tl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  tl_pkg::push_t  q_push,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tl_pkg::entry_t head
);
  import tl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = q_push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hdl/tl_back.sv
// Output stage of the token lexer: splits result groups into single results in an output register.
module tl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  tl_pkg::entry_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output tl_pkg::result_t res
);
  import tl_pkg::*;

  logic    phase;
  logic    load;

  assign load = (!out_valid || !out_stall) && !empty;
  assign pop  = load && (phase || !head.two);

  always_ff @(posedge clk) begin
    if (load) begin
      res <= phase ? head.r1 : head.r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !phase && head.two;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/token_lexer.sv
// Top level of the token lexer.
// A byte-serial lexer: one source byte or end-of-input mark per transaction, giving zero to two
// results (text characters, completed tokens, or an error). The front end takes one input
// transaction per cycle while its queue of QUEUE_DEPTH result groups has room; the output
// register delivers one result per cycle while out_stall is low, so when inputs yield two
// results sustained throughput is set by the output port. An accepted input's results pass
// through a queue slot and then the output register. After an error no further results appear
// until reset.
module token_lexer #(
  parameter int QUEUE_DEPTH = tl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_type,
  output logic [3:0] token_kind,
  output logic [7:0] text_char,
  output logic [1:0] error_code,
  output logic       last
);
  import tl_pkg::*;

  push_t   q_push;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  entry_t  q_head;
  result_t res;

  tl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  tl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .head   (q_head)
  );

  tl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign result_type = res.rtype;
  assign token_kind  = res.kind;
  assign text_char   = res.ch;
  assign error_code  = res.err;
  assign last        = res.last;

  // The second result of a pair follows its first without a gap.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("second result of a pair missing");

  // An error is always the final result of its input.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_type == R_ERROR)) |-> last)
    else $error("error result not marked last");

  // Text characters only belong to numbers and identifiers.
  a_char_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_type == R_CHAR)) |-> ((token_kind == K_NUMBER) ||
                                               (token_kind == K_IDENT)))
    else $error("text character with wrong token kind");

endmodule

>>> verif/tb_token_lexer.sv
// Self-checking testbench for the token lexer: byte stimulus, result prediction and scoreboard.
`timescale 1ns / 1ps

module tb_token_lexer;
  import tl_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_STRETCH = 300;
  localparam logic [1:0] NO_ERROR = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_COMMENT, S_GT, S_LT, S_COLON, S_KW_A, S_KW_AC, S_KW_ACT, S_KW_ACTI,
    S_KW_ACTIO, S_INT, S_FRAC, S_IDENT, S_FAIL
  } scan_state_e;

  class lex_scoreboard;
    scan_state_e st;
    result_t staged[$];
    result_t awaited[$];
    int errors;
    int checked;

    function new();
      st = S_IDLE;
      errors = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void emit(logic [1:0] t, logic [3:0] k, logic [7:0] c, logic [1:0] e);
      result_t r;
      r.rtype = t;
      r.kind = k;
      r.ch = c;
      r.err = e;
      r.last = 1'b0;
      staged.push_back(r);
    endfunction

    function void fail(logic [1:0] code);
      emit(R_ERROR, K_EOF, 8'h00, code);
      st = S_FAIL;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
    endfunction

    function bit is_word_start(logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER;
    endfunction

    function logic [7:0] keyword_next(scan_state_e s);
      case (s)
        S_COLON: return CH_LA;
        S_KW_A: return CH_C;
        S_KW_AC: return CH_T;
        S_KW_ACT: return CH_I;
        S_KW_ACTI: return CH_O;
        default: return CH_N;
      endcase
    endfunction

    function void from_idle(logic [7:0] c);
      case (c)
        CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
        CH_SEMI: st = S_COMMENT;
        CH_EQ: emit(R_TOKEN, K_EQ, 8'h00, NO_ERROR);
        CH_PLUS: emit(R_TOKEN, K_PLUS, 8'h00, NO_ERROR);
        CH_MINUS: emit(R_TOKEN, K_MINUS, 8'h00, NO_ERROR);
        CH_STAR: emit(R_TOKEN, K_STAR, 8'h00, NO_ERROR);
        CH_SLASH: emit(R_TOKEN, K_SLASH, 8'h00, NO_ERROR);
        CH_LPAREN: emit(R_TOKEN, K_LPAREN, 8'h00, NO_ERROR);
        CH_RPAREN: emit(R_TOKEN, K_RPAREN, 8'h00, NO_ERROR);
        CH_GT: st = S_GT;
        CH_LT: st = S_LT;
        CH_COLON: st = S_COLON;
        CH_DOT: begin
          emit(R_CHAR, K_NUMBER, c, NO_ERROR);
          st = S_FRAC;
        end
        default: begin
          if (is_digit(c)) begin
            emit(R_CHAR, K_NUMBER, c, NO_ERROR);
            st = S_INT;
          end else if (is_word_start(c)) begin
            emit(R_CHAR, K_IDENT, c, NO_ERROR);
            st = S_IDENT;
          end else begin
            fail(E_TOKEN);
          end
        end
      endcase
    endfunction

    function void scan_byte(logic [7:0] c);
      case (st)
        S_IDLE: from_idle(c);
        S_COMMENT: if (c == CH_CR || c == CH_LF) st = S_IDLE;
        S_GT, S_LT: begin
          if (c == CH_EQ) begin
            emit(R_TOKEN, (st == S_GT) ? K_GE : K_LE, 8'h00, NO_ERROR);
            st = S_IDLE;
          end else begin
            emit(R_TOKEN, (st == S_GT) ? K_GT : K_LT, 8'h00, NO_ERROR);
            st = S_IDLE;
            from_idle(c);
          end
        end
        S_COLON, S_KW_A, S_KW_AC, S_KW_ACT, S_KW_ACTI, S_KW_ACTIO: begin
          if (c != keyword_next(st)) begin
            fail(E_KEYWORD);
          end else if (st == S_KW_ACTIO) begin
            emit(R_TOKEN, K_ACTION, 8'h00, NO_ERROR);
            st = S_IDLE;
          end else begin
            st = scan_state_e'(st + 1);
          end
        end
        S_INT, S_FRAC: begin
          if (is_digit(c)) begin
            emit(R_CHAR, K_NUMBER, c, NO_ERROR);
          end else if (c == CH_DOT) begin
            if (st == S_FRAC) begin
              fail(E_NUMBER);
            end else begin
              emit(R_CHAR, K_NUMBER, c, NO_ERROR);
              st = S_FRAC;
            end
          end else begin
            emit(R_TOKEN, K_NUMBER, 8'h00, NO_ERROR);
            st = S_IDLE;
            from_idle(c);
          end
        end
        S_IDENT: begin
          if (is_digit(c) || is_word_start(c)) begin
            emit(R_CHAR, K_IDENT, c, NO_ERROR);
          end else begin
            emit(R_TOKEN, K_IDENT, 8'h00, NO_ERROR);
            st = S_IDLE;
            from_idle(c);
          end
        end
        default: ;
      endcase
    endfunction

    function void scan_end();
      case (st)
        S_IDLE, S_COMMENT: ;
        S_GT: emit(R_TOKEN, K_GT, 8'h00, NO_ERROR);
        S_LT: emit(R_TOKEN, K_LT, 8'h00, NO_ERROR);
        S_INT, S_FRAC: emit(R_TOKEN, K_NUMBER, 8'h00, NO_ERROR);
        S_IDENT: emit(R_TOKEN, K_IDENT, 8'h00, NO_ERROR);
        S_FAIL: return;
        default: begin
          fail(E_KEYWORD);
          return;
        end
      endcase
      emit(R_TOKEN, K_EOF, 8'h00, NO_ERROR);
      st = S_IDLE;
    endfunction

    function void scan(logic [7:0] b, logic e);
      result_t r;
      staged.delete();
      if (e) scan_end();
      else scan_byte(b);
      if (staged.size() > 0) begin
        r = staged.pop_back();
        r.last = 1'b1;
        staged.push_back(r);
      end
    endfunction

    function bit would_fail(logic [7:0] b, logic e);
      scan_state_e saved;
      bit hit;
      saved = st;
      scan(b, e);
      hit = (st == S_FAIL) && (saved != S_FAIL);
      st = saved;
      staged.delete();
      return hit;
    endfunction

    function void note_input(logic [7:0] b, logic e);
      scan(b, e);
      foreach (staged[i]) awaited.push_back(staged[i]);
    endfunction

    function void check(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result type %0d kind %0d char %02h err %0d last %0d",
                         got.rtype, got.kind, got.ch, got.err, got.last));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.rtype !== want.rtype)
        report($sformatf("result_type %0d, expected %0d", got.rtype, want.rtype));
      if (got.kind !== want.kind)
        report($sformatf("token_kind %0d, expected %0d", got.kind, want.kind));
      if (got.ch !== want.ch)
        report($sformatf("text_char %02h, expected %02h", got.ch, want.ch));
      if (got.err !== want.err)
        report($sformatf("error_code %0d, expected %0d", got.err, want.err));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic end_of_input = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] result_type;
  logic [3:0] token_kind;
  logic [7:0] text_char;
  logic [1:0] error_code;
  logic last;

  lex_scoreboard sb = new();
  int tx_idle = 12;
  int rx_idle = 65;
  int hold_cycles = 0;
  int cycles = 0;
  int items_sent = 0;
  int eoi_sent = 0;

  token_lexer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .end_of_input(end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_type(result_type),
    .token_kind(token_kind),
    .text_char(text_char),
    .error_code(error_code),
    .last(last)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               sb.awaited.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle);
    end
  end

  always @(posedge clk) begin
    result_t got;
    got.rtype = result_type;
    got.kind = token_kind;
    got.ch = text_char;
    got.err = error_code;
    got.last = last;
    if (!rst && out_valid && !out_stall) sb.check(got);
  end

  task automatic send_item(input logic [7:0] b, input logic e);
    if ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_input <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b, e);
    items_sent++;
    if (e) eoi_sent++;
  endtask

  // A byte that would make the lexer fail, such as a second dot in a fraction, is preceded by a space.
  task automatic send_byte(input logic [7:0] b);
    if (sb.would_fail(b, 1'b0)) send_item(CH_SPACE, 1'b0);
    send_item(b, 1'b0);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT);
    if (sb.awaited.size() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.awaited.size()));
      sb.awaited.delete();
    end
  endtask

  function automatic logic [7:0] pick_word_char(input bit first);
    int r;
    r = first ? $urandom_range(10, 62) : $urandom_range(0, 62);
    if (r < 10) return 8'(CH_0 + r);
    if (r < 36) return 8'(CH_LA + r - 10);
    if (r < 62) return 8'(CH_UA + r - 36);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic send_random_token();
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      case ($urandom_range(0, 8))
        0: send_byte(CH_EQ);
        1: send_byte(CH_PLUS);
        2: send_byte(CH_MINUS);
        3: send_byte(CH_STAR);
        4: send_byte(CH_SLASH);
        5: send_byte(CH_LPAREN);
        6: send_byte(CH_RPAREN);
        7: begin
          send_byte(CH_GT);
          if ($urandom_range(0, 1)) send_byte(CH_EQ);
        end
        default: begin
          send_byte(CH_LT);
          if ($urandom_range(0, 1)) send_byte(CH_EQ);
        end
      endcase
    end else if (pick < 45) begin
      send_byte(pick_word_char(1'b1));
      repeat ($urandom_range(0, 5)) send_byte(pick_word_char(1'b0));
    end else if (pick < 65) begin
      if ($urandom_range(0, 3) == 0) begin
        send_byte(CH_DOT);
        repeat ($urandom_range(0, 3)) send_byte(pick_digit());
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(pick_digit());
        if ($urandom_range(0, 1)) begin
          send_byte(CH_DOT);
          repeat ($urandom_range(0, 3)) send_byte(pick_digit());
        end
      end
    end else if (pick < 72) begin
      send_text(":action");
    end else if (pick < 87) begin
      repeat ($urandom_range(1, 2)) send_byte(pick_blank());
    end else if (pick < 95) begin
      send_byte(CH_SEMI);
      repeat ($urandom_range(0, 6)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
        send_byte(b);
      end
      send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic send_random_text(input int goal);
    while (items_sent < goal) send_random_token();
  endtask

  initial begin
    int error_pick;
    int silent_from;
    logic [7:0] b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_text("=>=<=+-*/()>_1.5;");
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_text(".:action<");
    send_item(8'h00, 1'b1);
    send_byte(CH_SEMI);
    send_item(8'hFF, 1'b1);

    send_random_text(items_sent + 150);
    hold_cycles <= HOLD_STRETCH;
    send_random_text(480);
    wait_drained();

    tx_idle = 65;
    rx_idle = 12;
    send_random_text(960);
    wait_drained();

    tx_idle = 0;
    rx_idle = 0;
    send_random_text(1440);
    wait_drained();

    // The lexer stays failed after one error, so the run ends with exactly one.
    error_pick = $urandom_range(0, 2);
    send_byte(CH_LF);
    case (error_pick)
      0: begin
        do b = 8'($urandom_range(0, 255)); while (!sb.would_fail(b, 1'b0));
        send_item(b, 1'b0);
      end
      1: begin
        send_text(":ac");
        if ($urandom_range(0, 1)) send_item(8'h00, 1'b1);
        else send_item(CH_LA, 1'b0);
      end
      default: begin
        send_text("7.2");
        send_item(CH_DOT, 1'b0);
      end
    endcase
    silent_from = items_sent;
    repeat (10) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    send_item(CH_PLUS, 1'b0);
    send_item(8'h00, 1'b1);
    wait_drained();
    repeat (12) @(posedge clk);

    $display("Sent %0d input transactions (%0d end-of-input marks); checked %0d results.",
             items_sent, eoi_sent, sb.checked);
    $display("Ended on a forced error of class %0d, then %0d inputs in the failed state.",
             error_pick, items_sent - silent_from);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
